[sv/plt_pkg.sv]
`default_nettype none

package plt_pkg;

	// Default sizes of the list storage.
	localparam int PLT_CAPACITY   = 128;
	localparam int PLT_DATA_WIDTH = 32;

	// Fixed widths of the request and response fields.
	localparam int FUNC_W = 3;
	localparam int POS_W  = 8;
	localparam int ITEM_W = 32;
	localparam int LEN_W  = 8;

	// Request operation codes.
	typedef enum logic [FUNC_W-1:0] {
		F_INSERT = 3'd0,
		F_REMOVE = 3'd1,
		F_READ   = 3'd2,
		F_WRITE  = 3'd3,
		F_CLEAR  = 3'd4
	} plt_func_t;

	// Source of the memory read address.
	typedef enum logic [1:0] {
		RA_DOWN,
		RA_UP,
		RA_POS
	} plt_rd_addr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         req_ready;
		logic         latch;
		logic         ptr_load_cnt;
		logic         ptr_load_pos;
		logic         ptr_dec;
		logic         ptr_inc;
		logic         mem_rd;
		plt_rd_addr_t ra;
		logic         mem_wr;
		logic         wr_item;
		logic         cnt_inc;
		logic         cnt_dec;
		logic         cnt_clr;
		logic         rsp_load;
		logic         res_ok;
		logic         res_rd;
	} plt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              req_valid;
		logic [FUNC_W-1:0] func;
		logic              ins_ok;
		logic              use_ok;
		logic              ptr_at_pos;
		logic              ptr_last;
		logic              out_free;
	} plt_sts_t;

endpackage

`default_nettype wire

[sv/plt_req_if.sv]
`default_nettype none

interface plt_req_if import plt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	logic [ITEM_W-1:0] item_value;

	modport source (output valid, output func, output position, output item_value,
		input ready);
	modport sink (input valid, input func, input position, input item_value,
		output ready);
endinterface

`default_nettype wire

[sv/plt_rsp_if.sv]
`default_nettype none

interface plt_rsp_if import plt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [ITEM_W-1:0] read_value;
	logic [LEN_W-1:0]  length;
	logic              empty_res;

	modport source (output valid, output ok, output read_value, output length,
		output empty_res, input ready);
	modport sink (input valid, input ok, input read_value, input length,
		input empty_res, output ready);
endinterface

`default_nettype wire

[sv/plt_dpath.sv]
`default_nettype none

module plt_dpath import plt_pkg::*; #(
	parameter int CAPACITY   = PLT_CAPACITY,
	parameter int DATA_WIDTH = PLT_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp,
	input  plt_cmd_t  cmd,
	output plt_sts_t  sts
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [FUNC_W-1:0]     func_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] item_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  out_valid_q;
	logic                  ok_out_q;
	logic [ITEM_W-1:0]     rd_out_q;
	logic [LEN_W-1:0]      len_out_q;
	logic                  empty_out_q;

	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      cnt_w;
	logic [CNT_W-1:0]      pos0;
	logic [CNT_W-1:0]      raddr;
	logic [CNT_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] wdata;

	assign pos_w = CMP_W'(pos_q);
	assign cnt_w = CMP_W'(cnt_q);
	assign pos0  = CNT_W'(pos_w - CMP_W'(1));

	always_comb begin
		sts.req_valid  = req.valid;
		sts.func       = func_q;
		sts.ins_ok     = (pos_q != '0) && (pos_w <= cnt_w + CMP_W'(1)) &&
			(cnt_w < CMP_W'(CAPACITY));
		sts.use_ok     = (pos_q != '0) && (pos_w <= cnt_w);
		sts.ptr_at_pos = (ptr_q == pos0);
		sts.ptr_last   = ((CMP_W'(ptr_q) + CMP_W'(1)) == cnt_w);
		sts.out_free   = !out_valid_q || rsp.ready;
	end

	always_comb begin
		case (cmd.ra)
			RA_DOWN: raddr = ptr_q - CNT_W'(1);
			RA_UP:   raddr = ptr_q + CNT_W'(1);
			RA_POS:  raddr = pos0;
			default: raddr = pos0;
		endcase
		waddr = cmd.wr_item ? pos0 : ptr_q;
		wdata = cmd.wr_item ? item_q : rdata_q;
	end

	assign req.ready = cmd.req_ready;

	// List storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= req.func;
			pos_q  <= req.position;
			item_q <= DATA_WIDTH'(req.item_value);
		end
		if (cmd.ptr_load_cnt) begin
			ptr_q <= cnt_q;
		end else if (cmd.ptr_load_pos) begin
			ptr_q <= pos0;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - CNT_W'(1);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
		if (cmd.rsp_load) begin
			ok_out_q    <= cmd.res_ok;
			rd_out_q    <= cmd.res_rd ? ITEM_W'(rdata_q) : '0;
			len_out_q   <= cnt_w[LEN_W-1:0];
			empty_out_q <= (cnt_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.ok         = ok_out_q;
	assign rsp.read_value = rd_out_q;
	assign rsp.length     = len_out_q;
	assign rsp.empty_res  = empty_out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= CMP_W'(CAPACITY))
		else $error("item count beyond capacity");

	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (CMP_W'(cnt_q) < CMP_W'(CAPACITY)))
		else $error("insert into a full list");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (CMP_W'(waddr) < CMP_W'(CAPACITY)))
		else $error("memory write outside the list");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> (!out_valid_q || rsp.ready))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

[sv/plt_ctrl.sv]
`default_nettype none

module plt_ctrl import plt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  plt_sts_t sts,
	output plt_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   ok_q, ok_d;
	logic   rd_q, rd_d;
	logic   is_insert;

	assign is_insert = (sts.func == F_INSERT);

	always_comb begin
		cmd     = '0;
		cmd.ra  = RA_POS;
		state_d = state_q;
		ok_d    = ok_q;
		rd_d    = rd_q;
		case (state_q)
			S_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				ok_d    = 1'b0;
				rd_d    = 1'b0;
				state_d = S_FINISH;
				case (sts.func)
					F_INSERT: begin
						if (sts.ins_ok) begin
							cmd.ptr_load_cnt = 1'b1;
							state_d          = S_SHIFT_RD;
						end
					end
					F_REMOVE: begin
						if (sts.use_ok) begin
							cmd.ptr_load_pos = 1'b1;
							state_d          = S_SHIFT_RD;
						end
					end
					F_READ: begin
						if (sts.use_ok) begin
							cmd.mem_rd = 1'b1;
							cmd.ra     = RA_POS;
							ok_d       = 1'b1;
							rd_d       = 1'b1;
						end
					end
					F_WRITE: begin
						if (sts.use_ok) begin
							cmd.mem_wr  = 1'b1;
							cmd.wr_item = 1'b1;
							ok_d        = 1'b1;
						end
					end
					F_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						ok_d        = 1'b1;
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			S_SHIFT_RD: begin
				if (is_insert) begin
					if (sts.ptr_at_pos) begin
						state_d = S_PUT;
					end else begin
						cmd.mem_rd = 1'b1;
						cmd.ra     = RA_DOWN;
						state_d    = S_SHIFT_WR;
					end
				end else begin
					if (sts.ptr_last) begin
						cmd.cnt_dec = 1'b1;
						ok_d        = 1'b1;
						state_d     = S_FINISH;
					end else begin
						cmd.mem_rd = 1'b1;
						cmd.ra     = RA_UP;
						state_d    = S_SHIFT_WR;
					end
				end
			end
			S_SHIFT_WR: begin
				cmd.mem_wr  = 1'b1;
				cmd.ptr_dec = is_insert;
				cmd.ptr_inc = !is_insert;
				state_d     = S_SHIFT_RD;
			end
			S_PUT: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_item = 1'b1;
				cmd.cnt_inc = 1'b1;
				ok_d        = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.rsp_load = 1'b1;
					cmd.res_ok   = ok_q;
					cmd.res_rd   = rd_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			rd_q    <= rd_d;
		end
	end

endmodule

`default_nettype wire

[sv/positional_list_table.sv]
// Positional list table: an ordered list of up to CAPACITY entries, numbered from one.
// Requests arrive as beats on the req channel (func, position, item_value) and each one
// produces exactly one response beat on the rsp channel (ok, read_value, length,
// empty_res). Both channels use a valid/ready handshake; a beat moves when both are high.
// One request is worked on at a time. Read, write, clear and any rejected request go
// from the decode state to the finish state, where their response is loaded. An insert
// or a remove moves the entries one at a time through the list memory, a read in one
// cycle and the write in the next, so the length of the shift sets how long it takes;
// an insert then writes the new item at its position and counts it in.
// The response sits in an output register, so the next request is accepted while an
// earlier response is still waiting; if the receiver stalls, the block finishes its
// current request and then holds until the output register is taken.
// Reset clears the item count, the output valid flag and the sequencer state; the list memory is not
// cleared, as no entry can be read before it has been written. No clearing pass is run,
// and a request may be presented in the first cycle after reset is released.
`default_nettype none

module positional_list_table import plt_pkg::*; #(
	parameter int CAPACITY   = PLT_CAPACITY,
	parameter int DATA_WIDTH = PLT_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp
);

	// Command and status bundles between the sequencer and the datapath.
	plt_cmd_t cmd;
	plt_sts_t sts;

	// The sequencer decides each request and steps through the entry shifts.
	plt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// The datapath holds the list memory, the item count and the response register.
	plt_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire
